/* hdl/spra_pkg.sv */
// Shared types, operation codes and per-channel arithmetic for the saturating RGB pixel ALU.
package spra_pkg;

	localparam int unsigned CH_W       = 8;
	localparam int unsigned KIND_W     = 3;
	localparam int unsigned PIPE_DEPTH = 5;  // four divider stages plus the output register

	localparam logic [CH_W-1:0] CH_MAX = '1;
	localparam logic [CH_W-1:0] CH_MIN = '0;

	typedef logic [CH_W-1:0] chan_t;

	typedef enum logic [KIND_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_INV = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4
	} op_t;

	// Load enables from the pipeline control to the lanes and the merge stage.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_out;
	} pipe_ctl_t;

	// Partial state of a restoring divide.
	typedef struct packed {
		chan_t rem;
		chan_t num;
		chan_t den;
		chan_t quo;
	} div_t;

	// What one lane hands to the merge stage.
	typedef struct packed {
		chan_t value;
		logic  eq;
		logic  lt;
		logic  gt;
	} lane_res_t;

	// Everything but divide: add, subtract, invert, multiply; unused codes give zero.
	function automatic chan_t simple_op(input logic [KIND_W-1:0] kind, input chan_t a,
			input chan_t b);
		logic [CH_W:0]     sum;
		logic [2*CH_W-1:0] prod;
		chan_t             res;
		sum  = {1'b0, a} + {1'b0, b};
		prod = a * b;
		unique case (kind)
			OP_ADD:  res = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
			OP_SUB:  res = (a > b) ? chan_t'(a - b) : CH_MIN;
			OP_INV:  res = CH_MAX - a;
			OP_MUL:  res = (|prod[2*CH_W-1:CH_W]) ? CH_MAX : prod[CH_W-1:0];
			default: res = CH_MIN;
		endcase
		return res;
	endfunction

	// One quotient bit. A zero divisor sets every bit, so the quotient comes out all ones.
	function automatic div_t div_step(input div_t d);
		logic [CH_W:0] trial;
		logic          fits;
		div_t          r;
		trial   = {d.rem, d.num[CH_W-1]};
		fits    = trial >= {1'b0, d.den};
		r.den   = d.den;
		r.num   = {d.num[CH_W-2:0], 1'b0};
		r.quo   = {d.quo[CH_W-2:0], fits};
		r.rem   = fits ? chan_t'(trial - {1'b0, d.den}) : trial[CH_W-1:0];
		return r;
	endfunction

endpackage

/* hdl/spra_lane.sv */
// One color channel: simple ops, compares and a four-stage restoring divider, two bits per stage.
module spra_lane (
	input  logic                        clk,
	input  spra_pkg::pipe_ctl_t         ctl,
	input  logic [spra_pkg::KIND_W-1:0] kind,
	input  spra_pkg::chan_t             a,
	input  spra_pkg::chan_t             b,
	output spra_pkg::lane_res_t         res
);

	typedef struct packed {
		spra_pkg::chan_t simple;
		logic            is_div;
		logic            eq;
		logic            lt;
		logic            gt;
		spra_pkg::div_t  div;
	} lane_stage_t;

	lane_stage_t     in_d;
	spra_pkg::div_t  div0;
	lane_stage_t     stage2_in, stage3_in, stage4_in;
	lane_stage_t     stage_s1, stage_s2, stage_s3, stage_s4;

	always_comb begin
		div0.rem    = '0;
		div0.num    = a;
		div0.den    = b;
		div0.quo    = '0;
		in_d.simple = spra_pkg::simple_op(kind, a, b);
		in_d.is_div = kind == spra_pkg::OP_DIV;
		in_d.eq     = a == b;
		in_d.lt     = a < b;
		in_d.gt     = a > b;
		in_d.div    = spra_pkg::div_step(spra_pkg::div_step(div0));
	end

	// each later stage resolves two more quotient bits and passes the rest along
	always_comb begin
		stage2_in     = stage_s1;
		stage2_in.div = spra_pkg::div_step(spra_pkg::div_step(stage_s1.div));
		stage3_in     = stage_s2;
		stage3_in.div = spra_pkg::div_step(spra_pkg::div_step(stage_s2.div));
		stage4_in     = stage_s3;
		stage4_in.div = spra_pkg::div_step(spra_pkg::div_step(stage_s3.div));
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			stage_s1 <= in_d;
		end
		if (ctl.ld_s2) begin
			stage_s2 <= stage2_in;
		end
		if (ctl.ld_s3) begin
			stage_s3 <= stage3_in;
		end
		if (ctl.ld_s4) begin
			stage_s4 <= stage4_in;
		end
	end

	assign res.value = stage_s4.is_div ? stage_s4.div.quo : stage_s4.simple;
	assign res.eq    = stage_s4.eq;
	assign res.lt    = stage_s4.lt;
	assign res.gt    = stage_s4.gt;

endmodule

/* hdl/spra_merge.sv */
// Output register: joins the three lanes and reduces their compares to the pixel flags.
module spra_merge (
	input  logic                clk,
	input  logic                ld,
	input  spra_pkg::lane_res_t red,
	input  spra_pkg::lane_res_t green,
	input  spra_pkg::lane_res_t blue,
	output spra_pkg::chan_t     out_red,
	output spra_pkg::chan_t     out_green,
	output spra_pkg::chan_t     out_blue,
	output logic                all_equal,
	output logic                all_at_most,
	output logic                all_at_least,
	output logic                all_below,
	output logic                all_above
);

	always_ff @(posedge clk) begin
		if (ld) begin
			out_red      <= red.value;
			out_green    <= green.value;
			out_blue     <= blue.value;
			all_equal    <= red.eq & green.eq & blue.eq;
			all_at_most  <= ~red.gt & ~green.gt & ~blue.gt;
			all_at_least <= ~red.lt & ~green.lt & ~blue.lt;
			all_below    <= red.lt & green.lt & blue.lt;
			all_above    <= red.gt & green.gt & blue.gt;
		end
	end

endmodule

/* hdl/spra_ctrl.sv */
// Pipeline control: stage valid bits and bubble-collapsing load enables.
module spra_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output spra_pkg::pipe_ctl_t ctl
);

	localparam int unsigned D = spra_pkg::PIPE_DEPTH;

	logic [D-1:0] vld_q;
	logic [D-1:0] rdy;

	// A stage may load when it is empty or its request moves on this cycle.
	always_comb begin
		rdy[D-1] = ~vld_q[D-1] | out_ready;
		for (int i = D - 2; i >= 0; i--) begin
			rdy[i] = ~vld_q[i] | rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < D; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_ready   = rdy[0];
	assign out_valid  = vld_q[D-1];
	assign ctl.ld_s1  = rdy[0];
	assign ctl.ld_s2  = rdy[1];
	assign ctl.ld_s3  = rdy[2];
	assign ctl.ld_s4  = rdy[3];
	assign ctl.ld_out = rdy[4];

	// Input is refused only when every stage is full.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> &vld_q)
		else $error("input stalled with a bubble in the pipeline");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted request did not enter the first stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !vld_q[D-2] |=> !out_valid)
		else $error("output stayed valid after its request was taken");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[D-2] && !rdy[D-1] |=> vld_q[D-2] && out_valid)
		else $error("request lost while the output was stalled");

endmodule

/* hdl/saturating_rgb_pixel_alu_core.sv */
// Top level of the saturating RGB pixel ALU: three channel lanes, pipeline control, merge.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------------
//   input    | in_valid / in_ready  | kind, first_{red,green,blue}, second_{red,...}
//   output   | out_valid/ out_ready | out_{red,green,blue}, all_* compare flags
//
// One request per clock while out_ready is held high. A request passes through four divider
// stages, each resolving two quotient bits per lane, then the output register.
// Reset clears the stage valid bits only; data registers are not reset.
// Stages load whenever empty or draining, so bubbles close up under an output stall
// and input is refused only when all five stages hold requests.
module saturating_rgb_pixel_alu_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [spra_pkg::KIND_W-1:0] kind,
	input  spra_pkg::chan_t             first_red,
	input  spra_pkg::chan_t             first_green,
	input  spra_pkg::chan_t             first_blue,
	input  spra_pkg::chan_t             second_red,
	input  spra_pkg::chan_t             second_green,
	input  spra_pkg::chan_t             second_blue,
	output logic                        out_valid,
	input  logic                        out_ready,
	output spra_pkg::chan_t             out_red,
	output spra_pkg::chan_t             out_green,
	output spra_pkg::chan_t             out_blue,
	output logic                        all_equal,
	output logic                        all_at_most,
	output logic                        all_at_least,
	output logic                        all_below,
	output logic                        all_above
);

	spra_pkg::pipe_ctl_t ctl;
	spra_pkg::lane_res_t res_red, res_green, res_blue;

	spra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	spra_lane u_lane_red (
		.clk  (clk),
		.ctl  (ctl),
		.kind (kind),
		.a    (first_red),
		.b    (second_red),
		.res  (res_red)
	);

	spra_lane u_lane_green (
		.clk  (clk),
		.ctl  (ctl),
		.kind (kind),
		.a    (first_green),
		.b    (second_green),
		.res  (res_green)
	);

	spra_lane u_lane_blue (
		.clk  (clk),
		.ctl  (ctl),
		.kind (kind),
		.a    (first_blue),
		.b    (second_blue),
		.res  (res_blue)
	);

	spra_merge u_merge (
		.clk          (clk),
		.ld           (ctl.ld_out),
		.red          (res_red),
		.green        (res_green),
		.blue         (res_blue),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.all_equal    (all_equal),
		.all_at_most  (all_at_most),
		.all_at_least (all_at_least),
		.all_below    (all_below),
		.all_above    (all_above)
	);

endmodule

/* tb/pixel_result_checker.sv */
// Result checker for the pixel ALU: predicts each result from the accepted request and compares.
module pixel_result_checker
	import spra_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	input  chan_t             first_red,
	input  chan_t             first_green,
	input  chan_t             first_blue,
	input  chan_t             second_red,
	input  chan_t             second_green,
	input  chan_t             second_blue,
	input  logic              out_valid,
	input  logic              out_ready,
	input  chan_t             out_red,
	input  chan_t             out_green,
	input  chan_t             out_blue,
	input  logic              all_equal,
	input  logic              all_at_most,
	input  logic              all_at_least,
	input  logic              all_below,
	input  logic              all_above,
	output int                errors,
	output int                pending,
	output int                requests,
	output int                results,
	output logic [7:0]        kinds_seen
);

	localparam int MAX_PRINTS = 20;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  eq;
		logic  le;
		logic  ge;
		logic  lt;
		logic  gt;
	} pixel_result_t;

	pixel_result_t expected_pixels[$];

	function automatic chan_t saturated_channel(logic [KIND_W-1:0] k, chan_t a, chan_t b);
		logic [CH_W:0]     total;
		logic [2*CH_W-1:0] product;
		chan_t             r;
		total   = {1'b0, a} + {1'b0, b};
		product = {{CH_W{1'b0}}, a} * {{CH_W{1'b0}}, b};
		case (k)
			OP_ADD:  r = (total > CH_MAX) ? CH_MAX : total[CH_W-1:0];
			OP_SUB:  r = (a > b) ? chan_t'(a - b) : CH_MIN;
			OP_INV:  r = CH_MAX - a;
			OP_MUL:  r = (product > CH_MAX) ? CH_MAX : product[CH_W-1:0];
			OP_DIV:  r = (b == CH_MIN) ? CH_MAX : chan_t'(a / b);
			default: r = CH_MIN;
		endcase
		return r;
	endfunction

	function automatic pixel_result_t predict_pixel(logic [KIND_W-1:0] k, chan_t fr, chan_t fg,
			chan_t fb, chan_t sr, chan_t sg, chan_t sb);
		pixel_result_t p;
		p.red   = saturated_channel(k, fr, sr);
		p.green = saturated_channel(k, fg, sg);
		p.blue  = saturated_channel(k, fb, sb);
		// flags look only at the pixels, never at the operation
		p.eq    = (fr == sr) && (fg == sg) && (fb == sb);
		p.le    = (fr <= sr) && (fg <= sg) && (fb <= sb);
		p.ge    = (fr >= sr) && (fg >= sg) && (fb >= sb);
		p.lt    = (fr < sr) && (fg < sg) && (fb < sb);
		p.gt    = (fr > sr) && (fg > sg) && (fb > sb);
		return p;
	endfunction

	task automatic report_mismatch(string what);
		if (errors < MAX_PRINTS)
			$display("ERROR at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic compare_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("result %0d field %s got %0d want %0d",
				results, name, got, want));
	endtask

	always @(posedge clk) begin
		pixel_result_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			errors     = 0;
			pending    = 0;
			requests   = 0;
			results    = 0;
			kinds_seen = '0;
		end else begin
			// retire before record: a result never belongs to a request of the same edge
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no request outstanding",
						results));
				end else begin
					want = expected_pixels.pop_front();
					compare_field("out_red", int'(out_red), int'(want.red));
					compare_field("out_green", int'(out_green), int'(want.green));
					compare_field("out_blue", int'(out_blue), int'(want.blue));
					compare_field("all_equal", int'(all_equal), int'(want.eq));
					compare_field("all_at_most", int'(all_at_most), int'(want.le));
					compare_field("all_at_least", int'(all_at_least), int'(want.ge));
					compare_field("all_below", int'(all_below), int'(want.lt));
					compare_field("all_above", int'(all_above), int'(want.gt));
				end
				results++;
			end
			if (in_valid && in_ready) begin
				expected_pixels.push_back(predict_pixel(kind, first_red, first_green,
					first_blue, second_red, second_green, second_blue));
				kinds_seen[kind] = 1'b1;
				requests++;
			end
			pending = expected_pixels.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// Testbench top for the pixel ALU core: clock, reset, request stimulus, output stalls, verdict.
module tb_top;
	import spra_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SQUEEZE_CYCLES = 60;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_MID = 3'd6;
	localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

	typedef enum int {
		PH_DIRECTED,
		PH_SQUEEZE,
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} phase_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [KIND_W-1:0] kind;
	chan_t             first_red;
	chan_t             first_green;
	chan_t             first_blue;
	chan_t             second_red;
	chan_t             second_green;
	chan_t             second_blue;
	logic              out_valid;
	logic              out_ready;
	chan_t             out_red;
	chan_t             out_green;
	chan_t             out_blue;
	logic              all_equal;
	logic              all_at_most;
	logic              all_at_least;
	logic              all_below;
	logic              all_above;

	int                errors;
	int                pending;
	int                requests;
	int                results;
	logic [7:0]        kinds_seen;
	phase_t            phase;
	int                cycles;

	saturating_rgb_pixel_alu_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.first_red    (first_red),
		.first_green  (first_green),
		.first_blue   (first_blue),
		.second_red   (second_red),
		.second_green (second_green),
		.second_blue  (second_blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.all_equal    (all_equal),
		.all_at_most  (all_at_most),
		.all_at_least (all_at_least),
		.all_below    (all_below),
		.all_above    (all_above)
	);

	pixel_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.first_red    (first_red),
		.first_green  (first_green),
		.first_blue   (first_blue),
		.second_red   (second_red),
		.second_green (second_green),
		.second_blue  (second_blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.all_equal    (all_equal),
		.all_at_most  (all_at_most),
		.all_at_least (all_at_least),
		.all_below    (all_below),
		.all_above    (all_above),
		.errors       (errors),
		.pending      (pending),
		.requests     (requests),
		.results      (results),
		.kinds_seen   (kinds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int sender_idle_pct(phase_t ph);
		case (ph)
			PH_SEND_IDLE: return 52;
			PH_BOTH:      return 37;
			default:      return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct(phase_t ph);
		case (ph)
			PH_RECV_STALL: return 52;
			PH_BOTH:       return 37;
			default:       return 0;
		endcase
	endfunction

	// corner values show up far more often than a flat draw would give them
	function automatic chan_t rand_chan();
		case ($urandom_range(0, 5))
			0:       return CH_MIN;
			1:       return CH_MAX;
			2:       return chan_t'($urandom_range(0, 15));
			default: return chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_px(logic [KIND_W-1:0] k, chan_t fr, chan_t fg, chan_t fb,
			chan_t sr, chan_t sg, chan_t sb, int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		kind         <= k;
		first_red    <= fr;
		first_green  <= fg;
		first_blue   <= fb;
		second_red   <= sr;
		second_green <= sg;
		second_blue  <= sb;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic rand_req(int idle_pct);
		logic [KIND_W-1:0] k;
		chan_t             a[3];
		chan_t             b[3];
		int                shape;
		int                i;
		if ($urandom_range(0, 9) == 0)
			k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
		else
			k = KIND_W'($urandom_range(OP_ADD, OP_DIV));
		// some pixel pairs are ordered on purpose so the all-channel flags get hit
		shape = $urandom_range(0, 7);
		for (i = 0; i < 3; i++) begin
			a[i] = rand_chan();
			case (shape)
				0:       b[i] = a[i];
				1:       b[i] = a[i] + chan_t'($urandom_range(0, CH_MAX - a[i]));
				2:       b[i] = chan_t'($urandom_range(0, a[i]));
				default: b[i] = rand_chan();
			endcase
		end
		send_px(k, a[0], a[1], a[2], b[0], b[1], b[2], idle_pct);
	endtask

	task automatic run_phase(phase_t ph, int count);
		phase <= ph;
		repeat (count)
			rand_req(sender_idle_pct(ph));
	endtask

	// receiver: random stalls per phase, plus one long hold-off when the squeeze phase opens
	initial begin
		phase_t seen_phase;
		int     hold_left;
		out_ready  = 1'b0;
		seen_phase = PH_DIRECTED;
		hold_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (phase != seen_phase) begin
				seen_phase = phase;
				if (phase == PH_SQUEEZE)
					hold_left = SQUEEZE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct(phase));
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		phase        = PH_DIRECTED;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = OP_ADD;
		first_red    = '0;
		first_green  = '0;
		first_blue   = '0;
		second_red   = '0;
		second_green = '0;
		second_blue  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// saturation edges, exact limits, zero divisors, unused codes, flag patterns
		send_px(OP_ADD, 255, 0, 128, 255, 0, 127, 0);
		send_px(OP_ADD, 128, 200, 1, 128, 55, 254, 0);
		send_px(OP_ADD, 0, 0, 0, 0, 0, 0, 0);
		send_px(OP_ADD, 1, 2, 3, 1, 5, 9, 0);
		send_px(OP_SUB, 0, 255, 100, 255, 0, 100, 0);
		send_px(OP_SUB, 10, 200, 7, 9, 1, 8, 0);
		send_px(OP_SUB, 9, 5, 3, 9, 2, 3, 0);
		send_px(OP_SUB, 1, 200, 3, 2, 100, 3, 0);
		send_px(OP_INV, 0, 255, 77, 1, 2, 3, 0);
		send_px(OP_INV, 255, 0, 128, 255, 0, 128, 0);
		send_px(OP_MUL, 16, 15, 255, 16, 17, 255, 0);
		send_px(OP_MUL, 0, 1, 2, 255, 200, 127, 0);
		send_px(OP_MUL, 255, 3, 85, 0, 85, 3, 0);
		send_px(OP_MUL, 255, 255, 255, 255, 255, 255, 0);
		send_px(OP_DIV, 7, 0, 255, 0, 2, 1, 0);
		send_px(OP_DIV, 0, 255, 100, 0, 255, 7, 0);
		send_px(OP_DIV, 255, 1, 9, 3, 255, 10, 0);
		send_px(OP_DIV, 0, 0, 0, 0, 0, 0, 0);
		send_px(OP_DIV, 255, 255, 255, 255, 255, 255, 0);
		send_px(KIND_UNUSED_LO, 200, 100, 50, 1, 2, 3, 0);
		send_px(KIND_UNUSED_MID, 1, 2, 3, 200, 100, 50, 0);
		send_px(KIND_UNUSED_HI, 255, 255, 255, 255, 255, 255, 0);

		run_phase(PH_SQUEEZE, 60);
		run_phase(PH_FREE, 100);
		run_phase(PH_SEND_IDLE, 100);
		run_phase(PH_RECV_STALL, 110);
		run_phase(PH_BOTH, 110);
		in_valid <= 1'b0;
		phase    <= PH_FREE;

		while (pending != 0)
			@(posedge clk);
		repeat (2 * PIPE_DEPTH) @(posedge clk);

		$display("Run covered %0d requests over %0d of 8 operation codes, %0d results checked",
			requests, $countones(kinds_seen), results);
		$display("Traffic: back-to-back, idle sender, stalling receiver, both, %s %0d cycles",
			"and a hold-off of", SQUEEZE_CYCLES);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
